// File: sv/fdsw_pkg.sv
// Shared constants, types and the segment table of the four-digit display writer.
// Used by fdsw_digits and four_digit_segment_display_writer. No dependencies.
package fdsw_pkg;

  localparam int unsigned ValueWidth = 14;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned NumBytes   = 10;
  localparam int unsigned CntWidth   = $clog2(NumBytes);

  localparam logic [ValueWidth-1:0] MaxValue = ValueWidth'(9999);
  localparam logic [7:0]            CmdByte  = 8'h48;

  // Digit address bytes, thousands first.
  localparam logic [7:0] AddrThousands = 8'h68;
  localparam logic [7:0] AddrHundreds  = 8'h6A;
  localparam logic [7:0] AddrTens      = 8'h6C;
  localparam logic [7:0] AddrUnits     = 8'h6E;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BRIGHTNESS   = 2'd0,
    REG_SEGMENT_MODE = 2'd1,
    REG_DISPLAY_ON   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_e;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] pattern_t;
  typedef pattern_t [NumDigits-1:0] pattern_arr_t;

  // Common-cathode pattern, bit 0 is segment a and bit 6 is segment g.
  function automatic pattern_t seg_pattern(input digit_t d);
    pattern_t p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: sv/fdsw_digits.sv
// Three-stage pipeline from a display value to four segment patterns.
// Depends on fdsw_pkg for widths, the saturation limit and the segment table.
module fdsw_digits (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [13:0]           show_value_i,
  output logic                  pat_valid_o,
  input  logic                  pat_ready_i,
  output fdsw_pkg::pattern_arr_t pat_o
);
  import fdsw_pkg::*;

  // Low four bits of ten times x; enough since the digit result is below ten.
  function automatic digit_t mul10_lo(input digit_t x);
    return digit_t'({x[0], 3'b000}) + digit_t'({x[2:0], 1'b0});
  endfunction

  logic                  s1_valid_q, s2_valid_q, s3_valid_q;
  logic                  s1_ready, s2_ready, s3_ready;
  logic [ValueWidth-1:0] value_q, value_d;
  digit_t                q1000_q, q100_q, q10_q, vlo_q;
  logic [27:0]           prod1000, prod100, prod10;
  digit_t                d1, d2, d3;
  pattern_arr_t          pat_q, pat_d;

  // Each stage moves when the next one is empty or moving too.
  assign s3_ready   = !s3_valid_q || pat_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Saturate at capture.
  assign value_d = (show_value_i > MaxValue) ? MaxValue : show_value_i;

  // Quotients by 1000, 100 and 10 through exact reciprocals over 0..9999.
  assign prod1000 = 28'(value_q) * 28'd8389;
  assign prod100  = 28'(value_q) * 28'd5243;
  assign prod10   = 28'(value_q) * 28'd6554;

  // Each lower digit is its quotient minus ten times the next higher one.
  assign d1 = q100_q - mul10_lo(q1000_q);
  assign d2 = q10_q - mul10_lo(q100_q);
  assign d3 = vlo_q - mul10_lo(q10_q);

  assign pat_d[0] = seg_pattern(q1000_q);
  assign pat_d[1] = seg_pattern(d1);
  assign pat_d[2] = seg_pattern(d2);
  assign pat_d[3] = seg_pattern(d3);

  // Valid flags of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) value_q <= value_d;
    if (s2_ready && s1_valid_q) begin
      q1000_q <= prod1000[26:23];
      q100_q  <= prod100[22:19];
      q10_q   <= prod10[19:16];
      vlo_q   <= value_q[3:0];
    end
    if (s3_ready && s2_valid_q) pat_q <= pat_d;
  end

  assign pat_valid_o = s3_valid_q;
  assign pat_o       = pat_q;

endmodule

// File: sv/four_digit_segment_display_writer.sv
// Top level of the four-digit display writer: config registers and byte sequencer.
// Depends on fdsw_pkg and fdsw_digits.
//
// Usage: a value word of 0 to 16383 enters on the in channel (in_valid_i, in_ready_o,
// show_value_i); values above 9999 show as 9999. Each value gives ten byte words on
// the out channel in bus order: command 0x48 and the control byte, then four frames
// of digit address and segment pattern, thousands first. frame_begin_o marks the first
// byte of a frame, frame_end_o the second, last_byte_o the tenth.
// The first byte of a value is valid once the value has passed the input register and
// the quotient register into the pattern register.
// One byte word goes out per cycle while the receiver is ready. The three-stage digit
// pipeline holds up to three values while bytes are sent, so input is stalled once
// values have arrived faster than their words go out, long enough to fill it.
// Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken; only
// the register's width of the data is kept and an index beyond the list is dropped.
// They are meant for idle periods, since the control byte reads the live registers.
// Reset empties the pipeline and sets brightness 1, segment mode 0, display on.
// When the receiver stalls, the current byte word holds until it is taken.
module four_digit_segment_display_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [13:0] show_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] bus_byte_o,
  output logic       frame_begin_o,
  output logic       frame_end_o,
  output logic       last_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import fdsw_pkg::*;

  logic                pat_valid, pat_ready;
  pattern_arr_t        pat;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [2:0]          brightness_q;
  logic                segment_mode_q, display_on_q;
  logic                last;
  logic [7:0]          ctrl_byte;

  fdsw_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .show_value_i(show_value_i),
    .pat_valid_o (pat_valid),
    .pat_ready_i (pat_ready),
    .pat_o       (pat)
  );

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q   <= 3'd1;
      segment_mode_q <= 1'b0;
      display_on_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_BRIGHTNESS:   brightness_q   <= cfg_data_i[2:0];
        REG_SEGMENT_MODE: segment_mode_q <= cfg_data_i[0];
        REG_DISPLAY_ON:   display_on_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ctrl_byte = {1'b0, brightness_q, segment_mode_q, 2'b00, display_on_q};

  // Byte counter over the ten words of one value.
  assign last      = (cnt_q == CntWidth'(NumBytes - 1));
  assign pat_ready = out_ready_i && last;
  assign cnt_d     = last ? '0 : cnt_q + CntWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (pat_valid && out_ready_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Byte selection by position in the run.
  always_comb begin
    unique case (cnt_q)
      4'd0:    bus_byte_o = CmdByte;
      4'd1:    bus_byte_o = ctrl_byte;
      4'd2:    bus_byte_o = AddrThousands;
      4'd3:    bus_byte_o = pat[0];
      4'd4:    bus_byte_o = AddrHundreds;
      4'd5:    bus_byte_o = pat[1];
      4'd6:    bus_byte_o = AddrTens;
      4'd7:    bus_byte_o = pat[2];
      4'd8:    bus_byte_o = AddrUnits;
      4'd9:    bus_byte_o = pat[3];
      default: bus_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o   = pat_valid;
  assign frame_begin_o = !cnt_q[0];
  assign frame_end_o   = cnt_q[0];
  assign last_byte_o   = last;

  // The counter never runs past the tenth word.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(NumBytes - 1))
    else $error("byte counter out of range");

  // A taken tenth word starts the next run at the command byte.
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> cnt_q == '0)
    else $error("counter did not wrap after the last word");

  // The last word closes a frame.
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> frame_end_o && !frame_begin_o)
    else $error("last word does not end a frame");

  // The counter only moves on a taken word.
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_ready_i) |=> $stable(cnt_q))
    else $error("counter moved without a taken word");

endmodule

// File: sim/fdsw_bus_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the four-digit display writer: follows the register writes, predicts the
// ten bus words of every accepted value and checks the out channel against them.
// Depends on fdsw_pkg.
module fdsw_bus_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [fdsw_pkg::ValueWidth-1:0] show_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      bus_byte_i,
  input  logic                            frame_begin_i,
  input  logic                            frame_end_i,
  input  logic                            last_byte_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     words_pending_o
);
  import fdsw_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       opens;
    logic       closes;
    logic       tail;
  } bus_word_t;

  // Segment glyphs of the digits 0 to 9, segment a in bit 0.
  localparam pattern_t Glyphs [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic [2:0] brightness_q;
  logic       eight_seg_q;
  logic       display_on_q;
  bus_word_t  bus_words [$];
  bus_word_t  seen_word;
  bus_word_t  want_word;

  // Pushes the ten words that one value puts on the bus, in bus order.
  function automatic void queue_display_words(input logic [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] shown;
    int unsigned           digit [NumDigits];
    logic [7:0]            addr  [NumDigits];
    logic [7:0]            ctrl;
    shown    = (value > MaxValue) ? MaxValue : value;
    digit[0] = shown / 1000;
    digit[1] = (shown / 100) % 10;
    digit[2] = (shown / 10) % 10;
    digit[3] = shown % 10;
    addr     = '{AddrThousands, AddrHundreds, AddrTens, AddrUnits};
    ctrl     = {1'b0, brightness_q, eight_seg_q, 2'b00, display_on_q};
    bus_words.push_back('{CmdByte, 1'b1, 1'b0, 1'b0});
    bus_words.push_back('{ctrl, 1'b0, 1'b1, 1'b0});
    for (int k = 0; k < NumDigits; k++) begin
      bus_words.push_back('{addr[k], 1'b1, 1'b0, 1'b0});
      bus_words.push_back('{Glyphs[digit[k]], 1'b0, 1'b1, k == NumDigits - 1});
    end
  endfunction

  // Track registers, predict on each value word and compare each byte word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q    = 3'd1;
      eight_seg_q     = 1'b0;
      display_on_q    = 1'b1;
      bus_words.delete();
      mismatches_o    = 0;
      words_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_index_e'(cfg_index_i))
          REG_BRIGHTNESS:   brightness_q = cfg_data_i[2:0];
          REG_SEGMENT_MODE: eight_seg_q  = cfg_data_i[0];
          REG_DISPLAY_ON:   display_on_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        queue_display_words(show_value_i);
      end
      if (out_valid_i && out_ready_i) begin
        seen_word = '{bus_byte_i, frame_begin_i, frame_end_i, last_byte_i};
        if (bus_words.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("Unexpected bus word: byte %02h begin %b end %b last %b",
                     seen_word.data, seen_word.opens, seen_word.closes, seen_word.tail);
          end
          mismatches_o++;
        end else begin
          want_word = bus_words.pop_front();
          if (seen_word !== want_word) begin
            if (mismatches_o < 10) begin
              $display("Bus word mismatch: expected byte %02h begin %b end %b last %b,",
                       want_word.data, want_word.opens, want_word.closes, want_word.tail);
              $display("  got byte %02h begin %b end %b last %b",
                       seen_word.data, seen_word.opens, seen_word.closes, seen_word.tail);
            end
            mismatches_o++;
          end
        end
      end
      words_pending_o = bus_words.size();
    end
  end

endmodule

// File: sim/four_digit_segment_display_writer_test.sv
`timescale 1ns / 100ps
// Testbench top of the four-digit display writer: drives values and register writes
// under three pacing modes and gives the verdict. Depends on fdsw_pkg and fdsw_bus_checker.
module four_digit_segment_display_writer_test;
  import fdsw_pkg::*;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [ValueWidth-1:0] show_value   = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [7:0]            bus_byte;
  logic                  frame_begin;
  logic                  frame_end;
  logic                  last_byte;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index    = '0;
  logic [7:0]            cfg_data     = '0;
  int unsigned           mismatch_count;
  int unsigned           words_pending;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 71;
  int unsigned values_sent   = 0;
  int unsigned settings_done = 0;

  // Digit extremes, every digit, saturation and both bit patterns of the value field.
  localparam logic [ValueWidth-1:0] Directed [18] = '{
    14'd0, 14'd1234, 14'd5678, 14'd9999, 14'd10000, 14'd16383, 14'd9000, 14'd8765,
    14'd4321, 14'd1, 14'd10, 14'd100, 14'd1000, 14'd9990, 14'd909, 14'h1555,
    14'h2AAA, 14'd7070
  };

  four_digit_segment_display_writer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .show_value_i  (show_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .bus_byte_o    (bus_byte),
    .frame_begin_o (frame_begin),
    .frame_end_o   (frame_end),
    .last_byte_o   (last_byte),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  fdsw_bus_checker bus_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .show_value_i    (show_value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .bus_byte_i      (bus_byte),
    .frame_begin_i   (frame_begin),
    .frame_end_i     (frame_end),
    .last_byte_i     (last_byte),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatch_count),
    .words_pending_o (words_pending)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random at the current rate.
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one value word, with random idle cycles first, and returns after it is taken.
  task automatic put_value(input logic [ValueWidth-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    show_value <= value;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    values_sent++;
  endtask

  task automatic write_reg(input reg_index_e index, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Writes all registers, with random upper bits, plus a write to the unused index.
  task automatic apply_settings(input logic [2:0] level, input logic eight_seg,
                                input logic enable);
    write_reg(REG_BRIGHTNESS, {5'($urandom), level});
    write_reg(REG_SEGMENT_MODE, {7'($urandom), eight_seg});
    write_reg(REG_DISPLAY_ON, {7'($urandom), enable});
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // Mostly displayable values, some small ones and some that saturate.
  function automatic logic [ValueWidth-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      return ValueWidth'($urandom_range(16383, 10000));
    end else if (pick < 22) begin
      return ValueWidth'($urandom_range(99));
    end
    return ValueWidth'($urandom_range(9999));
  endfunction

  // Stimulus: directed values under reset settings, then random values per pacing mode.
  initial begin
    int unsigned step;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (Directed[i]) begin
      put_value(Directed[i]);
    end
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int part = 0; part < 3; part++) begin
        wait_drained();
        step = phase * 3 + part;
        case (step)
          0: apply_settings(3'd7, 1'b1, 1'b0);
          1: apply_settings(3'd0, 1'b0, 1'b0);
          2: apply_settings(3'd0, 1'b1, 1'b1);
          3: apply_settings(3'd7, 1'b0, 1'b1);
          4: apply_settings(3'd1, 1'b0, 1'b1);
          default: apply_settings(3'($urandom), 1'($urandom), 1'($urandom));
        endcase
        for (int n = 0; n < 50; n++) begin
          put_value(random_value());
        end
      end
    end
    wait_drained();
    // Leave room for any stray word after the last expected one.
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d values under %0d register settings and three pacing modes.",
             values_sent, settings_done);
    $display("Bus word mismatches: %0d, words still expected: %0d.",
             mismatch_count, words_pending);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin
    #3_000_000;
    $display("Timeout with %0d words still expected.", words_pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
